/* rtl/clns_pkg.sv */
// ----------------------------------------------------------------------------
// clns_pkg
// Shared types and constants for the character LCD nibble sequencer.
// ----------------------------------------------------------------------------
package clns_pkg;

  // Request codes carried in the cmd field.
  typedef enum logic [2:0] {
    CMD_INIT  = 3'd0,
    CMD_BYTE  = 3'd1,
    CMD_DATA  = 3'd2,
    CMD_CLEAR = 3'd3,
    CMD_CURSOR = 3'd4,
    CMD_GLYPH = 3'd5
  } cmd_e;

  // How the back end expands a queued request.
  typedef enum logic [1:0] {
    KIND_SINGLE = 2'd0,
    KIND_INIT   = 2'd1,
    KIND_GLYPH  = 2'd2
  } kind_e;

  // Configuration register indexes (byte address divided by four).
  localparam logic REG_CURSOR_SHOWN  = 1'b0;
  localparam logic REG_CURSOR_BLINKS = 1'b1;

  // Controller command bytes.
  localparam logic [7:0] LCD_SET_DDRAM  = 8'h80;
  localparam logic [7:0] LCD_SET_CGRAM  = 8'h40;
  localparam logic [7:0] LCD_CLR_DISP   = 8'h01;
  localparam logic [7:0] LCD_DISP_CTRL  = 8'h0C;
  localparam logic [7:0] LCD_FUNC_8BIT  = 8'h30;
  localparam logic [7:0] LCD_FUNC_4BIT  = 8'h28;
  localparam logic [7:0] LCD_ENTRY_MODE = 8'h06;

  // Waits in microseconds after the strobe.
  localparam logic [11:0] WAIT_HI    = 12'd1;
  localparam logic [11:0] WAIT_LO    = 12'd37;
  localparam logic [11:0] WAIT_CLEAR = 12'd2037;
  localparam logic [11:0] WAIT_BOOT0 = 12'd4037;
  localparam logic [11:0] WAIT_BOOT1 = 12'd137;

  // Index of the final byte of each expansion.
  localparam logic [3:0] LAST_SINGLE = 4'd0;
  localparam logic [3:0] LAST_INIT   = 4'd5;
  localparam logic [3:0] LAST_GLYPH  = 4'd8;
  localparam logic [2:0] INIT_CTRL_IDX = 3'd3;

  // One request word as it arrives.
  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  byte_value;
    logic [1:0]  row_number;
    logic [4:0]  column_number;
    logic [2:0]  glyph_slot;
    logic [63:0] glyph_rows;
  } req_t;

  // One strobe word as it leaves.
  typedef struct packed {
    logic        reg_select;
    logic [3:0]  nibble;
    logic [11:0] wait_us;
    logic        last;
  } strobe_t;

  // Classified request held in the queue.
  typedef struct packed {
    kind_e       kind;
    logic        rs;
    logic        long_wait;
    logic [7:0]  byte_val;   // single byte, init display-control byte or glyph header
    logic [63:0] rows;
  } desc_t;

  // Fixed bytes of the power-up sequence.
  function automatic logic [7:0] init_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0, 3'd1: b = LCD_FUNC_8BIT;
      3'd2:       b = LCD_FUNC_4BIT;
      3'd3:       b = LCD_DISP_CTRL;
      3'd4:       b = LCD_CLR_DISP;
      3'd5:       b = LCD_ENTRY_MODE;
      default:    b = LCD_ENTRY_MODE;
    endcase
    return b;
  endfunction

  // Low-nibble waits of the power-up sequence.
  function automatic logic [11:0] init_wait(input logic [2:0] idx);
    logic [11:0] w;
    unique case (idx)
      3'd0:    w = WAIT_BOOT0;
      3'd1:    w = WAIT_BOOT1;
      3'd4:    w = WAIT_CLEAR;
      default: w = WAIT_LO;
    endcase
    return w;
  endfunction

endpackage

/* rtl/clns_front.sv */
// ----------------------------------------------------------------------------
// clns_front
// Accepts request words, decodes them and pushes a descriptor to the queue.
// ----------------------------------------------------------------------------
module clns_front #(
  parameter int ROWS    = 2,
  parameter int COLUMNS = 16
) (
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  clns_pkg::req_t       in_data_i,
  input  logic                 cursor_shown_i,
  input  logic                 cursor_blinks_i,
  input  logic                 full_i,
  output logic                 push_o,
  output clns_pkg::desc_t      push_desc_o
);

  localparam logic [2:0] RowMax = 3'(ROWS);
  localparam logic [5:0] ColMax = 6'(COLUMNS);
  localparam logic [6:0] ColOff = 7'(COLUMNS);

  logic       accept;
  logic [2:0] row_c;
  logic [2:0] row_m1;
  logic [5:0] col_c;
  logic [6:0] addr;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;

  // Clamp row and column into the display, zero repaired to one.
  always_comb begin
    row_c = {1'b0, in_data_i.row_number};
    if (row_c == 3'd0) begin
      row_c = 3'd1;
    end
    if (row_c > RowMax) begin
      row_c = RowMax;
    end
    col_c = {1'b0, in_data_i.column_number};
    if (col_c == 6'd0) begin
      col_c = 6'd1;
    end
    if (col_c > ColMax) begin
      col_c = ColMax;
    end
  end

  // Rows one and three start a line, two and four are 0x40 further on;
  // rows three and four follow the first two lines by one line width.
  assign row_m1 = row_c - 3'd1;
  assign addr   = {row_m1[0], 6'd0} + 7'(col_c - 6'd1) + (row_c[2] | row_c[1] & row_c[0]
                  ? ColOff : 7'd0);

  // Classify the request.
  always_comb begin
    push_o                = 1'b0;
    push_desc_o.kind      = clns_pkg::KIND_SINGLE;
    push_desc_o.rs        = 1'b0;
    push_desc_o.long_wait = 1'b0;
    push_desc_o.byte_val  = in_data_i.byte_value;
    push_desc_o.rows      = in_data_i.glyph_rows;
    unique case (clns_pkg::cmd_e'(in_data_i.cmd))
      clns_pkg::CMD_INIT: begin
        push_o               = accept;
        push_desc_o.kind     = clns_pkg::KIND_INIT;
        push_desc_o.byte_val = clns_pkg::LCD_DISP_CTRL | {6'd0, cursor_shown_i, cursor_blinks_i};
      end
      clns_pkg::CMD_BYTE: begin
        push_o = accept;
      end
      clns_pkg::CMD_DATA: begin
        push_o         = accept;
        push_desc_o.rs = 1'b1;
      end
      clns_pkg::CMD_CLEAR: begin
        push_o                = accept;
        push_desc_o.long_wait = 1'b1;
        push_desc_o.byte_val  = clns_pkg::LCD_CLR_DISP;
      end
      clns_pkg::CMD_CURSOR: begin
        push_o               = accept;
        push_desc_o.byte_val = clns_pkg::LCD_SET_DDRAM | {1'b0, addr};
      end
      clns_pkg::CMD_GLYPH: begin
        push_o               = accept;
        push_desc_o.kind     = clns_pkg::KIND_GLYPH;
        push_desc_o.byte_val = clns_pkg::LCD_SET_CGRAM | {2'b00, in_data_i.glyph_slot, 3'b000};
      end
      default: begin
        // Unused codes are taken and dropped.
        push_o = 1'b0;
      end
    endcase
  end

endmodule

/* rtl/clns_queue.sv */
// ----------------------------------------------------------------------------
// clns_queue
// Two-entry descriptor queue between the decoder and the strobe sequencer.
// ----------------------------------------------------------------------------
module clns_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  clns_pkg::desc_t push_desc_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output clns_pkg::desc_t pop_desc_o
);

  clns_pkg::desc_t slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_desc_o = slot_q[rd_ptr_q];

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_desc_i;
    end
  end

endmodule

/* rtl/clns_back.sv */
// ----------------------------------------------------------------------------
// clns_back
// Expands one descriptor into nibble strobes, one word per cycle while the
// output is not stalled, into an output register.
// ----------------------------------------------------------------------------
module clns_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  clns_pkg::desc_t  desc_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output clns_pkg::strobe_t out_data_o
);

  clns_pkg::desc_t   cur_q, cur_d;
  logic              busy_q, busy_d;
  logic [3:0]        idx_q, idx_d;
  logic              phase_q, phase_d;
  logic              out_valid_q, out_valid_d;
  clns_pkg::strobe_t out_word_q, out_word_d;

  logic              advance;
  logic              finish;
  logic [2:0]        row_sel;
  logic [7:0]        cur_byte;
  logic              cur_rs;
  logic [11:0]       lo_wait;
  logic [3:0]        last_idx;

  assign row_sel = 3'(idx_q - 4'd1);

  // Pick the byte, register select and low-nibble wait of the current step.
  always_comb begin
    cur_byte = cur_q.byte_val;
    cur_rs   = cur_q.rs;
    lo_wait  = cur_q.long_wait ? clns_pkg::WAIT_CLEAR : clns_pkg::WAIT_LO;
    last_idx = clns_pkg::LAST_SINGLE;
    unique case (cur_q.kind)
      clns_pkg::KIND_INIT: begin
        cur_rs   = 1'b0;
        cur_byte = (idx_q[2:0] == clns_pkg::INIT_CTRL_IDX) ? cur_q.byte_val
                                                           : clns_pkg::init_byte(idx_q[2:0]);
        lo_wait  = clns_pkg::init_wait(idx_q[2:0]);
        last_idx = clns_pkg::LAST_INIT;
      end
      clns_pkg::KIND_GLYPH: begin
        cur_rs   = (idx_q != 4'd0);
        cur_byte = (idx_q == 4'd0) ? cur_q.byte_val : cur_q.rows[{row_sel, 3'b000} +: 8];
        lo_wait  = clns_pkg::WAIT_LO;
        last_idx = clns_pkg::LAST_GLYPH;
      end
      default: begin
        last_idx = clns_pkg::LAST_SINGLE;
      end
    endcase
  end

  // While busy, the sequencer steps whenever the output register can take a word.
  assign advance = busy_q && (!out_valid_q || !out_stall_i);
  assign finish  = advance && phase_q && (idx_q == last_idx);
  assign pop_o   = !empty_i && (!busy_q || finish);

  always_comb begin
    cur_d   = cur_q;
    busy_d  = busy_q;
    idx_d   = idx_q;
    phase_d = phase_q;
    if (pop_o) begin
      cur_d   = desc_i;
      busy_d  = 1'b1;
      idx_d   = 4'd0;
      phase_d = 1'b0;
    end else if (finish) begin
      busy_d = 1'b0;
    end else if (advance) begin
      phase_d = !phase_q;
      if (phase_q) begin
        idx_d = idx_q + 4'd1;
      end
    end
  end

  // Output register: high nibble first, then the low nibble.
  always_comb begin
    out_word_d = out_word_q;
    if (advance) begin
      out_word_d.reg_select = cur_rs;
      out_word_d.nibble     = phase_q ? cur_byte[3:0] : cur_byte[7:4];
      out_word_d.wait_us    = phase_q ? lo_wait : clns_pkg::WAIT_HI;
      out_word_d.last       = phase_q && (idx_q == last_idx);
    end
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= 4'd0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_word_q;

endmodule

/* rtl/char_lcd_nibble_sequencer_core.sv */
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_core
// Turns LCD requests into enable-strobed nibble words for a 4-bit LCD bus.
// ----------------------------------------------------------------------------
// Each request word expands into strobe words, one per clock while the output
// is not stalled: a command, data, clear or cursor request gives two words,
// init gives twelve and glyph definition eighteen; codes six
// and seven are taken and give no word. The output register and the
// sequencer that fills it set this rate of one nibble per cycle; a two-entry
// queue lets new requests be taken while earlier ones are still being sent.
// Waits are reported in wait_us and must be carried out by a timer outside.
// Cursor flags come from two APB registers at byte addresses 0 and 4.
module char_lcd_nibble_sequencer_core #(
  parameter int ROWS    = 2,
  parameter int COLUMNS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  clns_pkg::req_t     in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output clns_pkg::strobe_t  out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic            cursor_shown_q, cursor_shown_d;
  logic            cursor_blinks_q, cursor_blinks_d;
  logic            cfg_write;
  logic            push;
  logic            pop;
  logic            full;
  logic            empty;
  clns_pkg::desc_t push_desc;
  clns_pkg::desc_t pop_desc;

  // Configuration registers.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    cursor_shown_d  = cursor_shown_q;
    cursor_blinks_d = cursor_blinks_q;
    if (cfg_write) begin
      unique case (paddr[2])
        clns_pkg::REG_CURSOR_SHOWN:  cursor_shown_d  = pwdata[0];
        clns_pkg::REG_CURSOR_BLINKS: cursor_blinks_d = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      clns_pkg::REG_CURSOR_SHOWN:  prdata = {31'd0, cursor_shown_q};
      clns_pkg::REG_CURSOR_BLINKS: prdata = {31'd0, cursor_blinks_q};
      default:                     prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_shown_q  <= 1'b0;
      cursor_blinks_q <= 1'b0;
    end else begin
      cursor_shown_q  <= cursor_shown_d;
      cursor_blinks_q <= cursor_blinks_d;
    end
  end

  // Request decoder.
  clns_front #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_front (
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_data_i       (in_data_i),
    .cursor_shown_i  (cursor_shown_q),
    .cursor_blinks_i (cursor_blinks_q),
    .full_i          (full),
    .push_o          (push),
    .push_desc_o     (push_desc)
  );

  // Descriptor queue.
  clns_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_desc_o  (pop_desc)
  );

  // Strobe sequencer.
  clns_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .desc_i      (pop_desc),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* rtl/clns_checker.sv */
// ----------------------------------------------------------------------------
// clns_checker
// Port-level checks on the strobe output of the nibble sequencer.
// ----------------------------------------------------------------------------
module clns_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input clns_pkg::strobe_t out_data_o
);

  // A stalled word stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output word changed");

  // Once a request has started, its words follow without a gap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last |=> out_valid_o)
    else $error("gap inside a request");

  // A high nibble is never the final strobe of a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.wait_us == clns_pkg::WAIT_HI) |-> !out_data_o.last)
    else $error("request ends on a high nibble");

  // Data-register strobes never carry an extra wait.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.reg_select |->
      (out_data_o.wait_us == clns_pkg::WAIT_HI) || (out_data_o.wait_us == clns_pkg::WAIT_LO))
    else $error("data strobe with long wait");

endmodule

bind char_lcd_nibble_sequencer_core clns_checker u_clns_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
